/* rtl/url_percent_codec_defines.svh */
// Assertion macros shared by the url_percent_codec RTL.
`ifndef URL_PERCENT_CODEC_DEFINES_SVH
`define URL_PERCENT_CODEC_DEFINES_SVH

// Same-cycle implication, checked on clk, off while rst_n is low.
`define UPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off while rst_n is low.
`define UPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/upc_pkg.sv */
// Shared types, character codes and helper functions for the URL codec.
package upc_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] HI_MASK  = 8'hF0;
  localparam logic [7:0] LO_MASK  = 8'h0F;
  localparam logic [4:0] NOT_HEX  = 5'd16;

  // Up to three output bytes produced by one input item.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } upc_cmd_t;

  // Uppercase hex character of a nibble.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] n8;
    n8 = {4'd0, nib};
    if (nib > 4'd9) hex_char = n8 - 8'd10 + 8'h41;
    else            hex_char = n8 + 8'h30;
  endfunction

  // Value of a hex digit, NOT_HEX when the byte is not one.
  function automatic logic [4:0] hex_val(input logic [7:0] b);
    logic [7:0] d;
    d = 8'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      hex_val = d[4:0];
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h61 + 8'd10;
      hex_val = d[4:0];
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h41 + 8'd10;
      hex_val = d[4:0];
    end else begin
      hex_val = NOT_HEX;
    end
  endfunction

  // Bytes that pass unchanged in encode mode.
  function automatic logic passes(input logic [7:0] b);
    logic alnum;
    alnum = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
            (b >= 8'h30 && b <= 8'h39);
    passes = alnum || b == 8'h2D || b == 8'h5F || b == 8'h2E || b == 8'h21 ||
             b == 8'h7E || b == 8'h2A || b == 8'h27 || b == 8'h28 || b == 8'h29 ||
             b == 8'h26 || b == 8'h3D || b == 8'h2F || b == 8'h5C || b == 8'h3F;
  endfunction

endpackage

/* rtl/url_percent_codec.sv */
// Top level of the URL percent encoder/decoder.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------
//  in_     | in  | in_tvalid/tready   | tdata[7:0]=in_byte, tlast=in_last
//  out_    | out | out_tvalid/tready  | tdata[7:0]=out_byte, tlast=out_last
//  cfg_    | in  | cfg_wr_en          | cfg_wr_data = direction
//
// Each item yields 0 to 3 output bytes; the back end sends one byte per cycle
// while out_tready is high. Three come from an escaped byte in encode mode, up
// to three from a broken escape in decode mode.
// The front end takes one item per cycle while the command queue has room; the
// first byte goes out through the queue, then the back end's command register.
// Reset (rst_n low, synchronous) selects encode mode and drops any escape.
// Either side may stall; the queue of FIFO_DEPTH commands absorbs the slip.
module url_percent_codec #(
  parameter int FIFO_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // configuration
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data,   // direction: 0 encode, 1 decode
  // input stream
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,      // [7:0] in_byte
  input  logic       in_tlast,      // in_last
  // result stream
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,     // [7:0] out_byte
  output logic       out_tlast      // out_last
);

  upc_pkg::upc_cmd_t push_cmd, pop_cmd;
  logic q_push, q_full, q_pop, q_valid;

  // classify and expand each accepted item
  upc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_cmd      (push_cmd)
  );

  // decouples input acceptance from output play-out
  upc_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_data(push_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .valid  (q_valid),
    .rd_data(pop_cmd)
  );

  // one output byte per cycle from the held command while out_tready is high
  upc_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_cmd    (pop_cmd),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_byte (out_tdata),
    .out_last (out_tlast)
  );

endmodule

/* rtl/upc_front.sv */
// Front end: accepts bytes, tracks escape state and builds output commands.
module upc_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic            cfg_wr_data,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            q_push,
  output upc_pkg::upc_cmd_t q_cmd
);

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  logic       dir_r;
  phase_t     phase_r, phase_nxt;
  logic [7:0] held_digit_r, held_nxt;

  logic [4:0] v, hv;
  logic       is_hex;
  logic       idle_go;
  logic [1:0] n;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (q_cmd.cnt != 2'd0);

  always_comb begin
    q_cmd     = '0;
    n         = 2'd0;
    phase_nxt = phase_r;
    held_nxt  = held_digit_r;
    idle_go   = 1'b0;
    v         = upc_pkg::hex_val(in_byte);
    hv        = upc_pkg::hex_val(held_digit_r);
    is_hex    = !v[4];
    if (!dir_r) begin
      if (in_byte == upc_pkg::CH_SPACE) begin
        q_cmd.bytes[n] = upc_pkg::CH_PLUS;  n = n + 2'd1;
      end else if (upc_pkg::passes(in_byte)) begin
        q_cmd.bytes[n] = in_byte;  n = n + 2'd1;
      end else begin
        q_cmd.bytes[n] = upc_pkg::CH_PCT;  n = n + 2'd1;
        q_cmd.bytes[n] = upc_pkg::hex_char(4'((in_byte & upc_pkg::HI_MASK) >> 4));
        n = n + 2'd1;
        q_cmd.bytes[n] = upc_pkg::hex_char(4'(in_byte & upc_pkg::LO_MASK));
        n = n + 2'd1;
      end
    end else begin
      unique case (phase_r)
        PH_PCT: begin
          phase_nxt = PH_IDLE;
          if (is_hex) begin
            if (in_last) begin
              q_cmd.bytes[n] = upc_pkg::CH_PCT;  n = n + 2'd1;
              q_cmd.bytes[n] = in_byte;          n = n + 2'd1;
            end else begin
              held_nxt  = in_byte;
              phase_nxt = PH_DIGIT;
            end
          end else begin
            q_cmd.bytes[n] = upc_pkg::CH_PCT;  n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        PH_DIGIT: begin
          phase_nxt = PH_IDLE;
          if (is_hex) begin
            q_cmd.bytes[n] = {hv[3:0], v[3:0]};  n = n + 2'd1;
          end else begin
            q_cmd.bytes[n] = upc_pkg::CH_PCT;  n = n + 2'd1;
            q_cmd.bytes[n] = held_digit_r;     n = n + 2'd1;
            idle_go = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          idle_go   = 1'b1;
        end
      endcase
      if (idle_go) begin
        if (in_byte == upc_pkg::CH_PCT) begin
          if (in_last) begin
            q_cmd.bytes[n] = upc_pkg::CH_PCT;  n = n + 2'd1;
          end else begin
            phase_nxt = PH_PCT;
          end
        end else begin
          q_cmd.bytes[n] = (in_byte == upc_pkg::CH_PLUS) ? upc_pkg::CH_SPACE : in_byte;
          n = n + 2'd1;
        end
      end
    end
    // a string always ends with no escape pending
    if (in_last) phase_nxt = PH_IDLE;
    q_cmd.cnt  = n;
    q_cmd.last = in_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r   <= 1'b0;
      phase_r <= PH_IDLE;
    end else if (cfg_wr_en) begin
      dir_r   <= cfg_wr_data;
      phase_r <= PH_IDLE;
    end else if (accept) begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_digit_r <= held_nxt;
  end

endmodule

/* rtl/upc_fifo.sv */
// Small command queue between the front and back ends.
`include "url_percent_codec_defines.svh"

module upc_fifo #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  upc_pkg::upc_cmd_t wr_data,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output upc_pkg::upc_cmd_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upc_pkg::upc_cmd_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;

  assign full    = (count_r == CW'(DEPTH));
  assign valid   = (count_r != '0);
  assign rd_data = mem[rd_ptr_r];

  function automatic logic [AW-1:0] inc(input logic [AW-1:0] p);
    inc = (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + CW'(1);
      else if (pop && !push) count_r <= count_r - CW'(1);
    end
  end

  `UPC_ASSERT_IMP(a_no_push_full, push, !full, "push into full queue")
  `UPC_ASSERT_IMP(a_no_pop_empty, pop, valid, "pop from empty queue")
  `UPC_ASSERT_IMP(a_count_range, 1'b1, count_r <= CW'(DEPTH), "queue count out of range")

endmodule

/* rtl/upc_back.sv */
// Back end: plays out queued commands one byte per cycle while out_ready is high.
`include "url_percent_codec_defines.svh"

module upc_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  upc_pkg::upc_cmd_t q_cmd,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);

  upc_pkg::upc_cmd_t cmd_r;
  logic [1:0]        idx_r;
  logic              busy_r;
  logic              at_end;
  logic              fire;

  assign at_end    = (idx_r == cmd_r.cnt - 2'd1);
  assign fire      = busy_r && out_ready;
  assign q_pop     = q_valid && (!busy_r || (fire && at_end));
  assign out_valid = busy_r;
  assign out_last  = cmd_r.last && at_end;

  always_comb begin
    unique case (idx_r)
      2'd0:    out_byte = cmd_r.bytes[0];
      2'd1:    out_byte = cmd_r.bytes[1];
      default: out_byte = cmd_r.bytes[2];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 2'd0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
      idx_r  <= 2'd0;
    end else if (fire) begin
      if (at_end) busy_r <= 1'b0;
      else        idx_r  <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cmd_r <= q_cmd;
  end

  `UPC_ASSERT_IMP(a_busy_cnt, busy_r, cmd_r.cnt != 2'd0, "empty command in play")
  `UPC_ASSERT_IMP(a_idx_range, busy_r, idx_r < cmd_r.cnt, "byte index past command")
  `UPC_ASSERT_NXT(a_stall_idx, busy_r && !out_ready, busy_r && $stable(idx_r),
                  "byte index moved while stalled")

endmodule

/* dv/url_percent_codec_test.sv */
// Self-checking testbench for the URL percent encoder/decoder (url_percent_codec).
module url_percent_codec_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Direction register values.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  // Cycles to let the block settle after the last expected byte.
  // The command queue holds 4 commands, each of up to 3 bytes.
  localparam int SETTLE_CYCLES = 16;
  // Cycles with no handshake on either channel before the run is called hung.
  localparam int HANG_LIMIT    = 5000;
  localparam int RANDOM_ITEMS  = 320;

  // Decoder escape progress.
  typedef enum logic [1:0] {ESC_IDLE, ESC_PCT, ESC_DIGIT} esc_phase_t;

  // One byte on either stream, with its end-of-string marker.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  // Predicts the converted byte stream and holds the bytes still owed by the block.
  class url_codec_tracker;
    logic       dir;
    esc_phase_t esc;
    logic [7:0] first_digit;
    text_byte_t due[$];
    text_byte_t fresh[$];
    int         errors;

    function new();
      dir = DIR_ENCODE;
      esc = ESC_IDLE;
      first_digit = 8'h00;
      errors = 0;
    endfunction

    // Any write drops a half-received escape.
    function void set_direction(logic d);
      dir = d;
      esc = ESC_IDLE;
    endfunction

    function void emit(logic [7:0] c);
      text_byte_t t;
      t.data = c;
      t.last = 1'b0;
      fresh.insert(fresh.size(), t);
    endfunction

    // 0..15 for a hex digit of either case, NOT_HEX otherwise.
    function logic [4:0] digit_value(logic [7:0] c);
      logic [7:0] folded;
      logic [4:0] v;
      folded = c | 8'h20;
      v = upc_pkg::NOT_HEX;
      if (c >= "0" && c <= "9") v = {1'b0, c[3:0]};
      else if (folded >= "a" && folded <= "f") v = {1'b0, c[3:0]} + 5'd9;
      return v;
    endfunction

    function logic [7:0] nibble_char(logic [3:0] n);
      return (n < 4'd10) ? ("0" + {4'd0, n}) : ("A" + {4'd0, n} - 8'd10);
    endfunction

    function logic is_safe(logic [7:0] c);
      if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"))
        return 1'b1;
      case (c)
        "-", "_", ".", "!", "~", "*", "'", "(", ")", "&", "=", "/", "\\", "?": return 1'b1;
        default: return 1'b0;
      endcase
    endfunction

    function void encode_char(logic [7:0] c);
      logic [7:0] hi;
      hi = (c & upc_pkg::HI_MASK) >> 4;
      if (c == upc_pkg::CH_SPACE) begin
        emit(upc_pkg::CH_PLUS);
      end else if (is_safe(c)) begin
        emit(c);
      end else begin
        emit(upc_pkg::CH_PCT);
        emit(nibble_char(hi[3:0]));
        emit(nibble_char(c[3:0] & upc_pkg::LO_MASK[3:0]));
      end
    endfunction

    // Byte seen with no escape pending; a '%' on the last byte stays literal.
    function void plain_char(logic [7:0] c, logic last);
      if (c == upc_pkg::CH_PCT) begin
        if (last) emit(upc_pkg::CH_PCT);
        else esc = ESC_PCT;
      end else begin
        emit(c == upc_pkg::CH_PLUS ? upc_pkg::CH_SPACE : c);
      end
    endfunction

    function void decode_char(logic [7:0] c, logic last);
      logic [4:0] v;
      logic [4:0] hv;
      v = digit_value(c);
      case (esc)
        ESC_PCT: begin
          esc = ESC_IDLE;
          if (v != upc_pkg::NOT_HEX) begin
            if (last) begin
              emit(upc_pkg::CH_PCT);
              emit(c);
            end else begin
              first_digit = c;
              esc = ESC_DIGIT;
            end
          end else begin
            // broken escape: '%' goes out literally, byte is reprocessed
            emit(upc_pkg::CH_PCT);
            plain_char(c, last);
          end
        end
        ESC_DIGIT: begin
          esc = ESC_IDLE;
          if (v != upc_pkg::NOT_HEX) begin
            hv = digit_value(first_digit);
            emit({hv[3:0], v[3:0]});
          end else begin
            emit(upc_pkg::CH_PCT);
            emit(first_digit);
            plain_char(c, last);
          end
        end
        default: begin
          esc = ESC_IDLE;
          plain_char(c, last);
        end
      endcase
    endfunction

    // Accepted input byte: queue the bytes it must produce.
    function void take_char(logic [7:0] c, logic last);
      fresh.delete();
      if (dir == DIR_DECODE) decode_char(c, last);
      else encode_char(c);
      if (last) begin
        esc = ESC_IDLE;
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
      end
      foreach (fresh[i]) due.insert(due.size(), fresh[i]);
    endfunction

    // Accepted output byte: compare against the oldest owed byte.
    function void match_char(logic [7:0] c, logic last);
      text_byte_t want;
      if (due.size() == 0) begin
        $display("%0t: unexpected out item data=%h last=%b", $time, c, last);
        errors++;
        return;
      end
      want = due.pop_front();
      if (want.data !== c) begin
        $display("%0t: out_byte mismatch: expected %h, actual %h", $time, want.data, c);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: out_last mismatch: expected %b, actual %b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic       cfg_wr_data = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;    // in_last
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic       out_tlast;          // out_last

  url_codec_tracker tracker;
  text_byte_t       stim[$];      // bytes of the string about to be sent
  int               idle_pct = 30; // percent of cycles each side holds off
  int               sent = 0;
  int               quiet_cycles = 0;

  url_percent_codec dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side: check every accepted byte and stall at random.
  // Values read right after the edge are the ones the block sampled.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.match_char(out_tdata, out_tlast);
    out_tready <= rst_n && ($urandom_range(99) >= idle_pct);
  end

  // Hang detector: any handshake clears the count.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void push(logic [7:0] c, logic last);
    text_byte_t t;
    t.data = c;
    t.last = last;
    stim.insert(stim.size(), t);
  endfunction

  // Random hex digit, letters in either case.
  function automatic logic [7:0] any_digit();
    logic [3:0] n;
    n = 4'($urandom_range(15));
    if (n < 4'd10) return "0" + {4'd0, n};
    return ($urandom_range(1) ? "a" : "A") + {4'd0, n} - 8'd10;
  endfunction

  function automatic logic maybe_last();
    return ($urandom_range(9) == 0);
  endfunction

  // One input item. Called right after a rising edge; holds valid until taken.
  task automatic send_item(logic [7:0] c, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.take_char(c, last);
    sent++;
  endtask

  // Drop valid and wait until every owed byte has come out.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.due.size() != 0) @(posedge clk);
  endtask

  // Send the queued string; drain_at >= 0 pauses the sender at that index.
  task automatic send_stim(int drain_at);
    foreach (stim[i]) begin
      if (i == drain_at) wait_drain();
      send_item(stim[i].data, stim[i].last);
    end
    stim.delete();
  endtask

  // Only written while idle. Bytes that yield nothing (a pending '%') may
  // still sit in the block after the last owed byte, so settle first.
  task automatic write_direction(logic d);
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_direction(d);
  endtask

  task automatic build_encode(int n);
    repeat (n) begin
      if ($urandom_range(9) < 4) push(8'($urandom_range(255)), maybe_last());
      else push(8'($urandom_range(8'h7E, 8'h20)), maybe_last());
    end
    stim[stim.size() - 1].last = 1'b1;
  endtask

  // Mostly well-formed escapes with random digits; the rest is noise.
  task automatic build_decode(int n);
    int r;
    while (stim.size() < n) begin
      r = $urandom_range(99);
      if (r < 50) begin
        push(upc_pkg::CH_PCT, maybe_last());
        push(any_digit(), maybe_last());
        push(any_digit(), maybe_last());
      end else if (r < 65) begin
        push(upc_pkg::CH_PLUS, maybe_last());
      end else if (r < 85) begin
        push(8'($urandom_range(8'h7E, 8'h20)), maybe_last());
      end else if (r < 92) begin
        // '%' followed by anything
        push(upc_pkg::CH_PCT, maybe_last());
        push(8'($urandom_range(255)), maybe_last());
      end else if (r < 97) begin
        // '%', one digit, then anything
        push(upc_pkg::CH_PCT, maybe_last());
        push(any_digit(), maybe_last());
        push(8'($urandom_range(255)), maybe_last());
      end else begin
        push(8'($urandom_range(255)), maybe_last());
      end
    end
    // Sometimes leave an escape half done so the next direction write drops it.
    if ($urandom_range(2) == 0) begin
      push(upc_pkg::CH_PCT, 1'b0);
      if ($urandom_range(1)) push(any_digit(), 1'b0);
    end else begin
      stim[stim.size() - 1].last = 1'b1;
    end
  endtask

  initial begin
    int  phase;
    logic d;
    tracker = new();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed encode: extremes, space, safe punctuation, '%' and '+'.
    write_direction(DIR_ENCODE);
    push(8'h00, 1'b0);
    push(8'hFF, 1'b0);
    push(upc_pkg::CH_SPACE, 1'b0);
    push("z", 1'b0);
    push("\\", 1'b0);
    push(upc_pkg::CH_PCT, 1'b0);
    push(upc_pkg::CH_PLUS, 1'b1);
    send_stim(-1);

    // Directed decode: mixed-case escape, '+', broken escapes after '%' and
    // after one digit, '%' restarting an escape, high byte, and escapes cut
    // by the end of the string.
    write_direction(DIR_DECODE);
    push(upc_pkg::CH_PCT, 1'b0); push("a", 1'b0); push("B", 1'b0);
    push(upc_pkg::CH_PLUS, 1'b0);
    push(upc_pkg::CH_PCT, 1'b0); push("G", 1'b0);
    push(upc_pkg::CH_PCT, 1'b0); push("4", 1'b0); push("x", 1'b0);
    push(upc_pkg::CH_PCT, 1'b0); push(upc_pkg::CH_PCT, 1'b0);
    push("2", 1'b0); push("0", 1'b0);
    push(8'hFF, 1'b0);
    push(upc_pkg::CH_PCT, 1'b0); push("F", 1'b1);
    push(upc_pkg::CH_PCT, 1'b1);
    send_stim(-1);

    // Random strings, mostly alternating direction; one phase runs with no
    // stalls on either side, one pauses the sender until drained.
    sent = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      d = phase[0] ? DIR_ENCODE : DIR_DECODE;
      if ($urandom_range(4) == 0) d = 1'($urandom_range(1));
      write_direction(d);
      idle_pct = (phase == 3) ? 0 : 30;
      if (d == DIR_DECODE) build_decode($urandom_range(50, 20));
      else build_encode($urandom_range(40, 15));
      send_stim((phase == 2) ? stim.size() / 2 : -1);
      phase++;
    end
    idle_pct = 30;

    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.due.size() != 0) begin
      $display("%0t: %0d expected out items never arrived", $time, tracker.due.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
